// File: sv/dbd_pkg.sv
// ============================================================================
// dbd_pkg
// Shared types, constants and the sigmoid table for the box decoder.
// ============================================================================
`default_nettype none

package dbd_pkg;

   // default sizes
   localparam int LIST_DEPTH_DEF   = 8;
   localparam int GRID_SIZE_DEF    = 16;
   localparam int ANCHOR_COUNT_DEF = 3;

   // stream widths
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 104;

   // register indexes
   localparam logic [1:0] CSR_SCORE_CUTOFF = 2'd0;
   localparam logic [1:0] CSR_CELL_PIXELS  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_MAX    = 2'd2;

   // reset values of the registers
   localparam logic [12:0] SCORE_CUTOFF_RST = 13'd2048;
   localparam logic [6:0]  CELL_PIXELS_RST  = 7'd16;
   localparam logic [11:0] IMAGE_MAX_RST    = 12'd255;

   // anchor sizes (half-extent scale), index 0..2
   localparam logic [2:0][6:0] ANCHOR_W = {7'd98, 7'd71, 7'd50};
   localparam logic [2:0][6:0] ANCHOR_H = {7'd91, 7'd74, 7'd50};

   // Q30 constants for the table build
   localparam logic [63:0] Q30_ONE      = 64'd1 << 30;
   localparam logic [63:0] EXP_STEP_Q30 = 64'd1057095000;

   typedef logic [255:0][12:0] sig_tab_type;

   // one list slot
   typedef struct packed {
      logic [12:0] class_b_prob;
      logic [12:0] class_a_prob;
      logic [12:0] score;
      logic [15:0] bottom;
      logic [15:0] right;
      logic [15:0] top;
      logic [15:0] left;
   } slot_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic lkp_en;
      logic mul_en;
      logic box_en;
      logic ins_en;
      logic shift_en;
      logic shift_last;
   } dbd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic keep;
      logic out_free;
   } dbd_sts_type;

   // Q30 multiply by e^(-1/64), rounded
   function automatic logic [63:0] exp_mul(input logic [63:0] a);
      logic [63:0] prod;
      prod = a * EXP_STEP_Q30 + (64'd1 << 29);
      return prod >> 30;
   endfunction

   // Positive half of the sigmoid, built at elaboration.
   // Entry k holds sigmoid at x = (2k+1)/64, by bitwise long division.
   function automatic sig_tab_type build_sig_tab();
      sig_tab_type tab;
      logic [63:0] p;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] quo;
      logic [63:0] rem;
      p = Q30_ONE;
      for (int k = 0; k < 256; k++) begin
         p = exp_mul(p);
         if (k > 0) begin
            p = exp_mul(p);
         end
         den = Q30_ONE + p;
         num = (64'd4096 << 30) + (den >> 1);
         quo = '0;
         rem = '0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
               rem    = rem - den;
               quo[b] = 1'b1;
            end
         end
         tab[k] = quo[12:0];
      end
      return tab;
   endfunction

   localparam sig_tab_type SIG_TAB = build_sig_tab();

   // Q4.12 logit to Q0.12 probability
   function automatic logic [12:0] sig_lookup(input logic [15:0] raw);
      logic [8:0] idx;
      idx = {~raw[15], raw[14:7]};
      if (idx[8]) begin
         return SIG_TAB[idx[7:0]];
      end
      return 13'd4096 - SIG_TAB[~idx[7:0]];
   endfunction

endpackage

`default_nettype wire

// File: sv/dbd_ctrl.sv
// ============================================================================
// dbd_ctrl
// Sequencer: steps a prediction through lookup, multiply, box and insert,
// or streams the list out on a drain request.
// ============================================================================
`default_nettype none

module dbd_ctrl #(
   parameter int LIST_DEPTH = dbd_pkg::LIST_DEPTH_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire                  req_tuser,
   input  dbd_pkg::dbd_sts_type sts,
   output dbd_pkg::dbd_cmd_type cmd
);

   localparam int CNT_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LKP   = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_BOX   = 3'd3;
   localparam logic [2:0] S_INS   = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             cnt_last;

   assign cnt_last   = (cnt_ff == CNT_W'(LIST_DEPTH - 1));
   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = req_tuser ? S_DRAIN : S_LKP;
            end
         end
         S_LKP: begin
            cmd.lkp_en = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_BOX;
         end
         S_BOX: begin
            cmd.box_en = 1'b1;
            state_in   = S_INS;
         end
         S_INS: begin
            cmd.ins_en = sts.keep;
            state_in   = S_IDLE;
         end
         S_DRAIN: begin
            if (sts.out_free) begin
               cmd.shift_en   = 1'b1;
               cmd.shift_last = cnt_last;
               cnt_in         = cnt_ff + CNT_W'(1);
               if (cnt_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/dbd_datapath.sv
// ============================================================================
// dbd_datapath
// Registers, sigmoid lookups, box arithmetic, the sorted slot list and the
// result output register.
// ============================================================================
`default_nettype none

module dbd_datapath #(
   parameter int LIST_DEPTH   = dbd_pkg::LIST_DEPTH_DEF,
   parameter int GRID_SIZE    = dbd_pkg::GRID_SIZE_DEF,
   parameter int ANCHOR_COUNT = dbd_pkg::ANCHOR_COUNT_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  dbd_pkg::dbd_cmd_type               cmd,
   output dbd_pkg::dbd_sts_type               sts,
   input  wire  [dbd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [1:0]                         csr_index,
   input  wire  [12:0]                        csr_wdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [dbd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);

   // configuration registers
   logic [12:0] thr_ff;
   logic [6:0]  cell_ff;
   logic [11:0] imax_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= dbd_pkg::SCORE_CUTOFF_RST;
         cell_ff <= dbd_pkg::CELL_PIXELS_RST;
         imax_ff <= dbd_pkg::IMAGE_MAX_RST;
      end else if (csr_valid) begin
         case (csr_index)
            dbd_pkg::CSR_SCORE_CUTOFF: thr_ff  <= csr_wdata;
            dbd_pkg::CSR_CELL_PIXELS:  cell_ff <= csr_wdata[6:0];
            dbd_pkg::CSR_IMAGE_MAX:    imax_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // request capture with grid and anchor saturation
   logic [3:0]  row_ff, col_ff, row_in, col_in;
   logic [1:0]  anc_ff, anc_in;
   logic [15:0] tx_ff, ty_ff, tw_ff, th_ff, tc_ff, ta_ff, tb_ff;

   always_comb begin
      row_in = req_tdata[3:0];
      col_in = req_tdata[7:4];
      anc_in = req_tdata[9:8];
      if ({3'd0, row_in} > 7'(GRID_SIZE - 1)) row_in = 4'(GRID_SIZE - 1);
      if ({3'd0, col_in} > 7'(GRID_SIZE - 1)) col_in = 4'(GRID_SIZE - 1);
      if (anc_in > 2'(ANCHOR_COUNT - 1))      anc_in = 2'(ANCHOR_COUNT - 1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff <= row_in;
         col_ff <= col_in;
         anc_ff <= anc_in;
         tx_ff  <= req_tdata[25:10];
         ty_ff  <= req_tdata[41:26];
         tw_ff  <= req_tdata[57:42];
         th_ff  <= req_tdata[73:58];
         tc_ff  <= req_tdata[89:74];
         ta_ff  <= req_tdata[105:90];
         tb_ff  <= req_tdata[121:106];
      end
   end

   // sigmoid lookups
   logic [12:0] sx_ff, sy_ff, sw_ff, sh_ff, conf_ff, pa_ff, pb_ff;

   always_ff @(posedge clock) begin
      if (cmd.lkp_en) begin
         sx_ff   <= dbd_pkg::sig_lookup(tx_ff);
         sy_ff   <= dbd_pkg::sig_lookup(ty_ff);
         sw_ff   <= dbd_pkg::sig_lookup(tw_ff);
         sh_ff   <= dbd_pkg::sig_lookup(th_ff);
         conf_ff <= dbd_pkg::sig_lookup(tc_ff);
         pa_ff   <= dbd_pkg::sig_lookup(ta_ff);
         pb_ff   <= dbd_pkg::sig_lookup(tb_ff);
      end
   end

   assign sts.keep = (conf_ff > thr_ff);

   // centre and half-size products
   logic [23:0] cxp_ff, cyp_ff;
   logic [19:0] hwp_ff, hhp_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         cxp_ff <= ({1'b0, col_ff, 12'd0} + {4'd0, sx_ff}) * {17'd0, cell_ff};
         cyp_ff <= ({1'b0, row_ff, 12'd0} + {4'd0, sy_ff}) * {17'd0, cell_ff};
         hwp_ff <= {7'd0, sw_ff} * {13'd0, dbd_pkg::ANCHOR_W[anc_ff]};
         hhp_ff <= {7'd0, sh_ff} * {13'd0, dbd_pkg::ANCHOR_H[anc_ff]};
      end
   end

   // corners with clamp to [0, image_max*16]
   function automatic logic [15:0] clamp_corner(input logic signed [17:0] v,
                                                input logic [15:0] hi);
      if (v < 0) begin
         return 16'd0;
      end
      if (v > $signed({2'b00, hi})) begin
         return hi;
      end
      return v[15:0];
   endfunction

   logic [23:0] cx_r, cy_r;
   logic [19:0] hw_r, hh_r;
   logic signed [17:0] cx_s, cy_s, hw_s, hh_s;
   logic [15:0] hi;
   logic [15:0] left_ff, top_ff, right_ff, bottom_ff;

   always_comb begin
      cx_r = cxp_ff + 24'd128;
      cy_r = cyp_ff + 24'd128;
      hw_r = hwp_ff + 20'd128;
      hh_r = hhp_ff + 20'd128;
      cx_s = $signed({2'b00, cx_r[23:8]});
      cy_s = $signed({2'b00, cy_r[23:8]});
      hw_s = $signed({6'd0, hw_r[19:8]});
      hh_s = $signed({6'd0, hh_r[19:8]});
      hi   = {imax_ff, 4'd0};
   end

   always_ff @(posedge clock) begin
      if (cmd.box_en) begin
         left_ff   <= clamp_corner(cx_s - hw_s, hi);
         top_ff    <= clamp_corner(cy_s - hh_s, hi);
         right_ff  <= clamp_corner(cx_s + hw_s, hi);
         bottom_ff <= clamp_corner(cy_s + hh_s, hi);
      end
   end

   // sorted slot list: compare-and-shift insert, shift-out drain
   dbd_pkg::slot_type slot_ff [LIST_DEPTH];
   dbd_pkg::slot_type slot_in [LIST_DEPTH];
   dbd_pkg::slot_type new_slot;
   logic [LIST_DEPTH-1:0] gt;

   always_comb begin
      new_slot.left         = left_ff;
      new_slot.top          = top_ff;
      new_slot.right        = right_ff;
      new_slot.bottom       = bottom_ff;
      new_slot.score        = conf_ff;
      new_slot.class_a_prob = pa_ff;
      new_slot.class_b_prob = pb_ff;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         gt[i] = (conf_ff > slot_ff[i].score);
      end
      for (int i = 0; i < LIST_DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
         if (cmd.ins_en && gt[i]) begin
            if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
               slot_in[i] = slot_ff[(i > 0) ? i - 1 : 0];
            end else begin
               slot_in[i] = new_slot;
            end
         end else if (cmd.shift_en) begin
            if (i < LIST_DEPTH - 1) begin
               slot_in[i] = slot_ff[(i < LIST_DEPTH - 1) ? i + 1 : i];
            end else begin
               slot_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIST_DEPTH; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < LIST_DEPTH; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   // result output register
   logic                  out_valid_ff;
   logic                  out_last_ff;
   dbd_pkg::slot_type     out_data_ff;

   assign sts.out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.shift_en) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift_en) begin
         out_data_ff <= slot_ff[0];
         out_last_ff <= cmd.shift_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// File: sv/detection_box_decode_topk.sv
// ============================================================================
// detection_box_decode_topk
// Detection head decoder with a confidence-sorted top-K box list.
// ============================================================================
// Usage:
//   req_* carries one request: tuser = func (0 prediction, 1 drain), tdata =
//   grid_row, grid_col, anchor_index, raw_tx/ty/tw/th, raw_conf, class logits.
//   A prediction steps through capture, sigmoid lookup, multiply, corner
//   clamp and list insert; the single-pass sequencer takes no new request
//   until the insert is done. It produces no result; if its score beats
//   the score cutoff its box is inserted into the sorted list.
//   A drain request emits LIST_DEPTH results on rsp_* (tlast on the final
//   one) by shifting the list out through an output register, one per cycle
//   while rsp_tready is high; the list is zero once the drain is done.
//   A stalled receiver holds the output register and pauses the drain; the
//   next request is accepted as soon as the drain has handed off its last
//   entry, even while that entry still waits.
//   csr_* writes the score cutoff (0), cell_pixels (1), image_max (2); it is
//   always ready; users write it only while the block is idle, unchecked.
//   Reset (synchronous) empties the list and restores register defaults.
// ============================================================================
`default_nettype none

module detection_box_decode_topk #(
   parameter int LIST_DEPTH   = dbd_pkg::LIST_DEPTH_DEF,
   parameter int GRID_SIZE    = dbd_pkg::GRID_SIZE_DEF,
   parameter int ANCHOR_COUNT = dbd_pkg::ANCHOR_COUNT_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // [3:0] grid_row, [7:4] grid_col, [9:8] anchor_index, [25:10] raw_tx,
   // [41:26] raw_ty, [57:42] raw_tw, [73:58] raw_th, [89:74] raw_conf,
   // [105:90] raw_class_a, [121:106] raw_class_b, rest zero
   input  wire  [dbd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] func
   input  wire                             req_tuser,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // [15:0] left, [31:16] top, [47:32] right, [63:48] bottom,
   // [76:64] score, [89:77] class_a_prob, [102:90] class_b_prob, [103] zero
   output logic [dbd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [1:0]                      csr_index,
   input  wire  [12:0]                     csr_wdata
);

   dbd_pkg::dbd_cmd_type cmd;
   dbd_pkg::dbd_sts_type sts;

   dbd_ctrl #(
      .LIST_DEPTH(LIST_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   dbd_datapath #(
      .LIST_DEPTH   (LIST_DEPTH),
      .GRID_SIZE    (GRID_SIZE),
      .ANCHOR_COUNT (ANCHOR_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // at most one datapath step per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.lkp_en, cmd.mul_en, cmd.box_en, cmd.ins_en, cmd.shift_en}))
      else $error("datapath commands overlap");

   // a list entry never overwrites a result still waiting
   a_shift_free: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_en |-> (!rsp_tvalid || rsp_tready))
      else $error("drain overwrote a pending result");

   // a drain request blocks new requests on the following cycle
   a_drain_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> !req_tready)
      else $error("request accepted during drain");

endmodule

`default_nettype wire
